// ===== hdl/qvr_pkg.sv =====
`timescale 1ns / 1ps
package qvr_pkg;

	localparam int QuatW = 16;
	localparam int VecW  = 32;
	localparam int CoefW = 2 * QuatW + 1;
	localparam int HalfW = VecW / 2;
	localparam int PhiW  = CoefW + HalfW;
	localparam int PloW  = CoefW + HalfW + 1;
	localparam int ShiW  = PhiW + 2;
	localparam int SloW  = PloW + 2;
	localparam int AccW  = ShiW + HalfW + 1;
	localparam int FracShift = 27;
	localparam int QW    = AccW - FracShift;

	localparam logic signed [QuatW-1:0] QuatWReset = 16'sd16384;
	localparam logic signed [QuatW-1:0] QuatXReset = 16'sd0;
	localparam logic signed [QuatW-1:0] QuatYReset = 16'sd0;
	localparam logic signed [QuatW-1:0] QuatZReset = 16'sd0;

	localparam logic signed [CoefW-1:0] OneQ27    = CoefW'(64'sd1 <<< FracShift);
	localparam logic signed [AccW-1:0]  RoundBias = AccW'(64'sd1 <<< (FracShift - 1));

	typedef enum logic [1:0] {
		REG_QUAT_W = 2'd0,
		REG_QUAT_X = 2'd1,
		REG_QUAT_Y = 2'd2,
		REG_QUAT_Z = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VecW-1:0] vec_u;
		logic signed [VecW-1:0] vec_v;
		logic signed [VecW-1:0] vec_w;
	} vec_in_t;

	typedef struct packed {
		logic signed [VecW-1:0] rot_u;
		logic signed [VecW-1:0] rot_v;
		logic signed [VecW-1:0] rot_w;
		logic                   saturated;
	} rot_out_t;

endpackage

// ===== hdl/quaternion_vector_rotator_top.sv =====
`timescale 1ns / 1ps
// quaternion vector rotator
// input channel in_valid/in_ready carries one vector word (vec_u, vec_v, vec_w, Q16.16);
// output channel out_valid/out_ready returns the rotated word (rot_u, rot_v, rot_w, Q16.16)
// with a saturated flag set when any component clipped to the 32-bit range.
// configuration channel cfg_valid/cfg_ready writes one Q1.14 quaternion component per word,
// cfg_index 0..3 selects w, x, y, z; cfg_ready is always high. write only while idle.
// throughput: one word per cycle unless out_ready stalls or a configuration write settles;
// five register stages (input, 18 partial products, row sums, rounding,
// saturation/output), each with its own valid bit.
// the rotation matrix is rebuilt from the quaternion in two registered steps, so
// in_ready drops for one cycle after each configuration write and after reset.
// reset: quaternion returns to (1,0,0,0), the identity, and the pipeline empties.
// a receiver stall holds the output word; each stage keeps taking words while it has
// room, so in_ready stays high until the pipeline is full.
module quaternion_vector_rotator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qvr_pkg::vec_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qvr_pkg::rot_out_t  out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  qvr_pkg::cfg_reg_t  cfg_index,
	input  logic [15:0]        cfg_data
);
	import qvr_pkg::*;

	logic signed [QuatW-1:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [2*QuatW-1:0] twx_q, twy_q, twz_q, txx_q, txy_q, txz_q, tyy_q, tyz_q, tzz_q;
	logic signed [CoefW-1:0] mat_q [3][3];
	logic settle_q;
	logic cfg_wr;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [HalfW-1:0] hi_s1 [3];
	logic [HalfW-1:0]        lo_s1 [3];
	logic signed [PhiW-1:0]  phi_s2 [3][3];
	logic signed [PloW-1:0]  plo_s2 [3][3];
	logic signed [ShiW-1:0]  shi_s3 [3];
	logic signed [SloW-1:0]  slo_s3 [3];
	logic signed [AccW-1:0]  acc [3];
	logic signed [QW-1:0]    q_s4 [3];
	logic signed [VecW-1:0]  sat_val [3];
	logic [2:0]              sat_hit;
	rot_out_t                out_s5;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// quaternion registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= QuatWReset;
			qx_q <= QuatXReset;
			qy_q <= QuatYReset;
			qz_q <= QuatZReset;
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_wr;
			if (cfg_wr) begin
				case (cfg_index)
					REG_QUAT_W: qw_q <= $signed(cfg_data);
					REG_QUAT_X: qx_q <= $signed(cfg_data);
					REG_QUAT_Y: qy_q <= $signed(cfg_data);
					REG_QUAT_Z: qz_q <= $signed(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// pairwise products, then matrix
	always_ff @(posedge clk) begin
		twx_q <= (2*QuatW)'(qw_q) * (2*QuatW)'(qx_q);
		twy_q <= (2*QuatW)'(qw_q) * (2*QuatW)'(qy_q);
		twz_q <= (2*QuatW)'(qw_q) * (2*QuatW)'(qz_q);
		txx_q <= (2*QuatW)'(qx_q) * (2*QuatW)'(qx_q);
		txy_q <= (2*QuatW)'(qx_q) * (2*QuatW)'(qy_q);
		txz_q <= (2*QuatW)'(qx_q) * (2*QuatW)'(qz_q);
		tyy_q <= (2*QuatW)'(qy_q) * (2*QuatW)'(qy_q);
		tyz_q <= (2*QuatW)'(qy_q) * (2*QuatW)'(qz_q);
		tzz_q <= (2*QuatW)'(qz_q) * (2*QuatW)'(qz_q);

		mat_q[0][0] <= OneQ27 - (CoefW'(tyy_q) + CoefW'(tzz_q));
		mat_q[0][1] <= CoefW'(txy_q) + CoefW'(twz_q);
		mat_q[0][2] <= CoefW'(txz_q) - CoefW'(twy_q);
		mat_q[1][0] <= CoefW'(txy_q) - CoefW'(twz_q);
		mat_q[1][1] <= OneQ27 - (CoefW'(txx_q) + CoefW'(tzz_q));
		mat_q[1][2] <= CoefW'(twx_q) + CoefW'(tyz_q);
		mat_q[2][0] <= CoefW'(twy_q) + CoefW'(txz_q);
		mat_q[2][1] <= CoefW'(tyz_q) - CoefW'(twx_q);
		mat_q[2][2] <= OneQ27 - (CoefW'(txx_q) + CoefW'(tyy_q));
	end

	// stage enables
	assign en_s5 = !v_s5 || out_ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1 && !settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && in_ready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// s1: split each component into signed high and unsigned low halves
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid && in_ready) begin
			hi_s1[0] <= in_data.vec_u[VecW-1:HalfW];
			hi_s1[1] <= in_data.vec_v[VecW-1:HalfW];
			hi_s1[2] <= in_data.vec_w[VecW-1:HalfW];
			lo_s1[0] <= in_data.vec_u[HalfW-1:0];
			lo_s1[1] <= in_data.vec_v[HalfW-1:0];
			lo_s1[2] <= in_data.vec_w[HalfW-1:0];
		end
	end

	// s2: partial products
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					phi_s2[r][c] <= PhiW'(mat_q[r][c]) * PhiW'(hi_s1[c]);
					plo_s2[r][c] <= PloW'(mat_q[r][c]) * PloW'($signed({1'b0, lo_s1[c]}));
				end
			end
		end
	end

	// s3: row sums
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int r = 0; r < 3; r++) begin
				shi_s3[r] <= ShiW'(phi_s2[r][0]) + ShiW'(phi_s2[r][1]) + ShiW'(phi_s2[r][2]);
				slo_s3[r] <= SloW'(plo_s2[r][0]) + SloW'(plo_s2[r][1]) + SloW'(plo_s2[r][2]);
			end
		end
	end

	// s4: join halves, round to nearest with ties up
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = (AccW'(shi_s3[r]) <<< HalfW) + AccW'(slo_s3[r]) + RoundBias;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int r = 0; r < 3; r++) begin
				q_s4[r] <= acc[r][AccW-1:FracShift];
			end
		end
	end

	// s5: saturate to 32 bits
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sat_hit[r] = 1'b0;
			sat_val[r] = q_s4[r][VecW-1:0];
			if (!q_s4[r][QW-1] && (|q_s4[r][QW-2:VecW-1])) begin
				sat_hit[r] = 1'b1;
				sat_val[r] = {1'b0, {(VecW-1){1'b1}}};
			end else if (q_s4[r][QW-1] && !(&q_s4[r][QW-2:VecW-1])) begin
				sat_hit[r] = 1'b1;
				sat_val[r] = {1'b1, {(VecW-1){1'b0}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			out_s5.rot_u     <= sat_val[0];
			out_s5.rot_v     <= sat_val[1];
			out_s5.rot_w     <= sat_val[2];
			out_s5.saturated <= |sat_hit;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

	// no word enters while settle_q marks a matrix rebuild
	a_settle_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		settle_q |-> !in_ready)
		else $error("input accepted while matrix rebuilds");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> settle_q)
		else $error("configuration write did not block input");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s5 |=> v_s4 && $stable(q_s4[0]) && $stable(q_s4[1]) && $stable(q_s4[2]))
		else $error("stalled stage lost its word");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.rot_u == 32'sh7fffffff) || (out_data.rot_u == 32'sh80000000) ||
			(out_data.rot_v == 32'sh7fffffff) || (out_data.rot_v == 32'sh80000000) ||
			(out_data.rot_w == 32'sh7fffffff) || (out_data.rot_w == 32'sh80000000))
		else $error("saturated flag without a clipped component");

endmodule

// ===== test/tb_quaternion_vector_rotator_top.sv =====
`timescale 1ns / 1ps
module tb_quaternion_vector_rotator_top;
	import qvr_pkg::*;

	localparam int HoldCycles = 300;
	localparam int QuietLimit = 2000;
	localparam int NumPhases = 10;
	localparam int PhaseItems = 173;

	localparam longint OneUnit = 64'sd1 <<< FracShift;
	localparam logic signed [127:0] HalfLsb = 128'sd1 <<< (FracShift - 1);
	localparam logic signed [127:0] SatHi = 128'sd2147483647;
	localparam logic signed [127:0] SatLo = -128'sd2147483648;

	typedef enum logic [1:0] {
		ROW_QUAT,
		ROW_TYPED,
		ROW_PRED
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [95:0] word;
		rot_out_t    want;
	} dir_row_t;

	// quaternion rows hold {w, x, y, z} in the low 64 bits
	localparam dir_row_t DirTab [26] = '{
		'{ROW_TYPED, {32'h00000000, 32'h00000000, 32'h00000000},
			{32'h00000000, 32'h00000000, 32'h00000000, 1'b0}},
		'{ROW_TYPED, {32'h7fffffff, 32'h80000000, 32'h00000001},
			{32'h7fffffff, 32'h80000000, 32'h00000001, 1'b0}},
		'{ROW_TYPED, {32'h80000000, 32'h7fffffff, 32'hffffffff},
			{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0}},
		'{ROW_TYPED, {32'h12345678, 32'h9abcdef0, 32'h55555555},
			{32'h12345678, 32'h9abcdef0, 32'h55555555, 1'b0}},
		// scalar part alone never reaches the diagonal
		'{ROW_QUAT, {32'h0, 16'h8000, 16'h0000, 16'h0000, 16'h0000}, '0},
		'{ROW_TYPED, {32'h7fffffff, 32'h80000000, 32'h00010000},
			{32'h7fffffff, 32'h80000000, 32'h00010000, 1'b0}},
		// half turn about x
		'{ROW_QUAT, {32'h0, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, '0},
		'{ROW_TYPED, {32'h00000001, 32'h00000002, 32'h00000003},
			{32'h00000001, 32'hfffffffe, 32'hfffffffd, 1'b0}},
		'{ROW_TYPED, {32'h00000000, 32'h80000000, 32'h7fffffff},
			{32'h00000000, 32'h7fffffff, 32'h80000001, 1'b1}},
		// unnormalised, x = -2 scales v and w by -7
		'{ROW_QUAT, {32'h0, 16'h0000, 16'h8000, 16'h0000, 16'h0000}, '0},
		'{ROW_TYPED, {32'h00010000, 32'h00010000, 32'hffff0000},
			{32'h00010000, 32'hfff90000, 32'h00070000, 1'b0}},
		'{ROW_TYPED, {32'h00000000, 32'h7fffffff, 32'h00000000},
			{32'h00000000, 32'h80000000, 32'h00000000, 1'b1}},
		// z = 0.5 halves u and v, ties round upwards
		'{ROW_QUAT, {32'h0, 16'h0000, 16'h0000, 16'h0000, 16'h2000}, '0},
		'{ROW_TYPED, {32'h00000001, 32'hffffffff, 32'h00000005},
			{32'h00000001, 32'h00000000, 32'h00000005, 1'b0}},
		'{ROW_TYPED, {32'h00000003, 32'hfffffffd, 32'h80000000},
			{32'h00000002, 32'hffffffff, 32'h80000000, 1'b0}},
		'{ROW_QUAT, {32'h0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, '0},
		'{ROW_PRED, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, '0},
		'{ROW_PRED, {32'h80000000, 32'h80000000, 32'h80000000}, '0},
		'{ROW_PRED, {32'h7fffffff, 32'h80000000, 32'h00000000}, '0},
		'{ROW_QUAT, {32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, '0},
		'{ROW_PRED, {32'h80000000, 32'h7fffffff, 32'h80000000}, '0},
		'{ROW_PRED, {32'h00010000, 32'h00020000, 32'h00030000}, '0},
		// quarter turn about z
		'{ROW_QUAT, {32'h0, 16'h2d41, 16'h0000, 16'h0000, 16'h2d41}, '0},
		'{ROW_PRED, {32'h00010000, 32'h00000000, 32'h00000000}, '0},
		'{ROW_PRED, {32'h00000000, 32'h00010000, 32'h00008000}, '0},
		'{ROW_PRED, {32'h12345678, 32'hfedcba98, 32'h00c0ffee}, '0}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	vec_in_t   in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	rot_out_t  out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_reg_t  cfg_index = REG_QUAT_W;
	logic [15:0] cfg_data = '0;

	logic signed [15:0] quat_reg [4] = '{QuatWReset, QuatXReset, QuatYReset, QuatZReset};
	rot_out_t rot_expect_q [$];
	int err_count = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;
	bit hold_pending = 1'b0;

	quaternion_vector_rotator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rot_out_t rotate_vec(input vec_in_t v);
		longint qw, qx, qy, qz;
		longint twx, twy, twz, txx, txy, txz, tyy, tyz, tzz;
		logic signed [127:0] coef [9];
		logic signed [127:0] comp [3];
		logic signed [127:0] acc;
		logic [31:0] res [3];
		rot_out_t rot;
		qw = longint'(quat_reg[REG_QUAT_W]);
		qx = longint'(quat_reg[REG_QUAT_X]);
		qy = longint'(quat_reg[REG_QUAT_Y]);
		qz = longint'(quat_reg[REG_QUAT_Z]);
		twx = qw * qx;
		twy = qw * qy;
		twz = qw * qz;
		txx = qx * qx;
		txy = qx * qy;
		txz = qx * qz;
		tyy = qy * qy;
		tyz = qy * qz;
		tzz = qz * qz;
		coef[0] = 128'(OneUnit - (tyy + tzz));
		coef[1] = 128'(txy + twz);
		coef[2] = 128'(txz - twy);
		coef[3] = 128'(txy - twz);
		coef[4] = 128'(OneUnit - (txx + tzz));
		coef[5] = 128'(twx + tyz);
		coef[6] = 128'(twy + txz);
		coef[7] = 128'(tyz - twx);
		coef[8] = 128'(OneUnit - (txx + tyy));
		comp[0] = 128'($signed(v.vec_u));
		comp[1] = 128'($signed(v.vec_v));
		comp[2] = 128'($signed(v.vec_w));
		rot.saturated = 1'b0;
		for (int r = 0; r < 3; r++) begin
			acc = coef[3*r] * comp[0] + coef[3*r+1] * comp[1] + coef[3*r+2] * comp[2];
			acc = (acc + HalfLsb) >>> FracShift;
			if (acc > SatHi) begin
				res[r] = SatHi[31:0];
				rot.saturated = 1'b1;
			end else if (acc < SatLo) begin
				res[r] = SatLo[31:0];
				rot.saturated = 1'b1;
			end else
				res[r] = acc[31:0];
		end
		rot.rot_u = res[0];
		rot.rot_v = res[1];
		rot.rot_w = res[2];
		return rot;
	endfunction

	function automatic logic [31:0] rand_comp();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: return {{12{r[19]}}, r[19:0]};
			3: begin
				case (r[2:0])
					3'd0: return 32'h7fffffff;
					3'd1: return 32'h80000000;
					3'd2: return 32'h00000000;
					3'd3: return 32'hffffffff;
					default: return r;
				endcase
			end
			default: return r;
		endcase
	endfunction

	function automatic logic [15:0] rand_quat_part();
		case ($urandom_range(0, 2))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h4000;
					3: return 16'hc000;
					default: return 16'h0000;
				endcase
			end
		endcase
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want_v);
		err_count++;
		$display("mismatch %s: got %h want %h", field, got, want_v);
	endtask

	task automatic send_vec(input logic [95:0] word, input bit typed, input rot_out_t want);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= vec_in_t'(word);
		do @(posedge clk); while (in_ready !== 1'b1);
		rot_expect_q.push_back(typed ? want : rotate_vec(vec_in_t'(word)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (rot_expect_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_quat(input logic [63:0] qv);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= qv[63-16*i -: 16];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			quat_reg[i] = qv[63-16*i -: 16];
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : stim
		logic [63:0] qv;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DirTab[i]) begin
			case (DirTab[i].kind)
				ROW_QUAT: begin
					drain();
					set_quat(DirTab[i].word[63:0]);
				end
				ROW_TYPED: send_vec(DirTab[i].word, 1'b1, DirTab[i].want);
				default: send_vec(DirTab[i].word, 1'b0, '0);
			endcase
		end
		for (int phase = 0; phase < NumPhases; phase++) begin
			drain();
			for (int i = 0; i < 4; i++)
				qv[63-16*i -: 16] = rand_quat_part();
			set_quat(qv);
			idle_on = (phase < NumPhases - 2) && (phase != 4);
			// long receiver stall so the pipeline backs up
			if (phase == 2)
				hold_pending = 1'b1;
			repeat (PhaseItems)
				send_vec({rand_comp(), rand_comp(), rand_comp()}, 1'b0, '0);
		end
		drain();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	always begin : rx_ready
		@(posedge clk);
		if (hold_pending) begin
			hold_pending = 1'b0;
			out_ready <= 1'b0;
			repeat (HoldCycles) @(posedge clk);
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin : check_words
		rot_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (rot_expect_q.size() == 0)
				report_mismatch("unexpected word", out_data.rot_u, '0);
			else begin
				want = rot_expect_q.pop_front();
				if (out_data.rot_u !== want.rot_u)
					report_mismatch("rot_u", out_data.rot_u, want.rot_u);
				if (out_data.rot_v !== want.rot_v)
					report_mismatch("rot_v", out_data.rot_v, want.rot_v);
				if (out_data.rot_w !== want.rot_w)
					report_mismatch("rot_w", out_data.rot_w, want.rot_w);
				if (out_data.saturated !== want.saturated)
					report_mismatch("saturated", 32'(out_data.saturated),
						32'(want.saturated));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
				|| (cfg_valid && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QuietLimit) begin
			$display("status: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule

// ===== filelist.f =====
hdl/qvr_pkg.sv
hdl/quaternion_vector_rotator_top.sv
test/tb_quaternion_vector_rotator_top.sv
